### rtl/all_pkg.sv
// Package for the array linked list engine: operation and status codes,
// sequencer state type. No dependencies.
package all_pkg;
	localparam logic [2:0] OP_PUSH_FRONT  = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK   = 3'd1;
	localparam logic [2:0] OP_INSERT_AFTER = 3'd2;
	localparam logic [2:0] OP_ERASE_ORDER = 3'd3;
	localparam logic [2:0] OP_ERASE_SLOT  = 3'd4;
	localparam logic [2:0] OP_READ_ORDER  = 3'd5;
	localparam logic [2:0] OP_READ_SLOT   = 3'd6;
	localparam logic [2:0] OP_CONTAINS    = 3'd7;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_BAD_SLOT  = 3'd2;
	localparam logic [2:0] ST_RANGE     = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	localparam int unsigned POISON_VALUE = 30234;

	typedef enum logic [10:0] {
		S_INIT   = 11'b00000000001,
		S_IDLE   = 11'b00000000010,
		S_DEC    = 11'b00000000100,
		S_WALK   = 11'b00000001000,
		S_WALKR  = 11'b00000010000,
		S_SRCH   = 11'b00000100000,
		S_SRCHR  = 11'b00001000000,
		S_RDS    = 11'b00010000000,
		S_LINK   = 11'b00100000000,
		S_FIX    = 11'b01000000000,
		S_OUT    = 11'b10000000000
	} state_t;
endpackage

### rtl/array_linked_list_engine.sv
// Array linked list engine, top level: sequencer over link, data and used-flag memories.
// Depends on all_pkg and all_mem.
//
// One operation is in flight at a time; tready is high only while idle. After
// reset a clearing pass over slots 0 to SLOTS builds the free chain before the
// first transfer. Order lookups on a non-linear list and contains walk the
// list one element at a time, since each step waits on the registered read of
// the next-link memory.
module array_linked_list_engine import all_pkg::*; #(
	parameter int SLOTS = 256,
	parameter int DATA_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// op[2:0], value, order, slot (lowest first), zero padded
	input  logic [((3+DATA_BITS+2*($clog2(SLOTS+1)))+7)/8*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// status[2:0], result_slot, result_value, found, count, head_slot, tail_slot
	output logic [((4+DATA_BITS+4*($clog2(SLOTS+1)))+7)/8*8-1:0] m_tdata
);
	localparam int SW = $clog2(SLOTS+1);
	localparam int OW = 4+DATA_BITS+4*SW;
	localparam int OWP = (OW+7)/8*8;
	localparam logic [SW-1:0] NSL = SW'(SLOTS);

	state_t st_q;
	logic [2:0] op_q, status_q;
	logic [DATA_BITS-1:0] val_q, rval_q;
	logic [SW-1:0] ord_q, sl_q, rslot_q, cnt_q, head_q, tail_q, free_q;
	logic [SW-1:0] s_q, p_q, n_q, idx_q, init_q;
	logic found_q, lin_q;
	logic [2:0] step_q;

	// memories
	logic nx_we, pv_we, dt_we, us_we, us_wd, us_rd;
	logic [SW-1:0] nx_wa, nx_wd, nx_ra, nx_rd, pv_wa, pv_wd, pv_ra, pv_rd, dt_wa, dt_ra;
	logic [SW-1:0] us_wa, us_ra;
	logic [DATA_BITS-1:0] dt_wd, dt_rd;
	all_mem #(.AW(SW), .DW(SW)) u_next (.clk, .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
		.raddr(nx_ra), .rdata(nx_rd));
	all_mem #(.AW(SW), .DW(SW)) u_prev (.clk, .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
		.raddr(pv_ra), .rdata(pv_rd));
	all_mem #(.AW(SW), .DW(DATA_BITS)) u_data (.clk, .we(dt_we), .waddr(dt_wa),
		.wdata(dt_wd), .raddr(dt_ra), .rdata(dt_rd));
	all_mem #(.AW(SW), .DW(1)) u_used (.clk, .we(us_we), .waddr(us_wa), .wdata(us_wd),
		.raddr(us_ra), .rdata(us_rd));

	function automatic logic [SW-1:0] clip(input logic [SW-1:0] x);
		return (x <= NSL) ? x : '0;
	endfunction

	logic [2:0] i_op;
	logic [DATA_BITS-1:0] i_val;
	logic [SW-1:0] i_ord, i_sl;
	assign i_op  = s_tdata[2:0];
	assign i_val = s_tdata[3 +: DATA_BITS];
	assign i_ord = s_tdata[3+DATA_BITS +: SW];
	assign i_sl  = s_tdata[3+DATA_BITS+SW +: SW];

	assign s_tready = (st_q == S_IDLE);
	assign m_tvalid = (st_q == S_OUT);
	assign m_tdata = OWP'({tail_q, head_q, cnt_q, found_q, rval_q, rslot_q, status_q});

	logic is_ins, is_slotop;
	assign is_ins = (op_q == OP_PUSH_FRONT) || (op_q == OP_PUSH_BACK) ||
		(op_q == OP_INSERT_AFTER);
	assign is_slotop = (op_q == OP_ERASE_SLOT) || (op_q == OP_READ_SLOT);

	// used flag of the requested slot is ready in S_RDS, the state after S_DEC
	assign us_ra = sl_q;

	// memory port drive: step_q sequences link updates inside S_LINK / S_FIX
	always_comb begin
		nx_we = 1'b0; nx_wa = s_q; nx_wd = '0;
		pv_we = 1'b0; pv_wa = s_q; pv_wd = '0;
		dt_we = 1'b0; dt_wa = s_q; dt_wd = val_q;
		us_we = 1'b0; us_wa = s_q; us_wd = 1'b0;
		nx_ra = s_q; pv_ra = s_q; dt_ra = s_q;
		case (st_q)
			S_INIT: begin
				nx_we = 1'b1; nx_wa = init_q;
				nx_wd = (init_q == '0 || init_q == NSL) ? '0 : init_q + SW'(1);
				pv_we = 1'b1; pv_wa = init_q;
				us_we = 1'b1; us_wa = init_q;
			end
			S_WALK: nx_ra = p_q;
			S_SRCH: nx_ra = s_q;
			S_LINK: begin
				if (is_ins) begin
					case (step_q)
						3'd0: begin
							dt_we = 1'b1; pv_we = 1'b1; pv_wd = p_q;
							nx_we = 1'b1; nx_wd = n_q;
							us_we = 1'b1; us_wd = 1'b1;
						end
						3'd1: begin
							if (p_q != '0) begin
								nx_we = 1'b1; nx_wa = p_q; nx_wd = s_q;
							end
							if (n_q != '0) begin
								pv_we = 1'b1; pv_wa = n_q; pv_wd = s_q;
							end
						end
						default: ;
					endcase
				end else begin
					case (step_q)
						3'd0: begin
							nx_ra = s_q; pv_ra = s_q; dt_ra = s_q;
						end
						3'd2: begin
							if (p_q != '0) begin
								nx_we = 1'b1; nx_wa = p_q; nx_wd = n_q;
							end
							if (n_q != '0) begin
								pv_we = 1'b1; pv_wa = n_q; pv_wd = p_q;
							end
						end
						3'd3: begin
							nx_we = 1'b1; nx_wd = free_q;
							pv_we = 1'b1; pv_wd = '0;
							us_we = 1'b1; us_wd = 1'b0;
						end
						default: ;
					endcase
				end
			end
			// next of p first, then next of the free slot
			S_FIX: begin
				nx_ra = (step_q == 3'd0) ? p_q : s_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_INIT; init_q <= '0; cnt_q <= '0; head_q <= '0; tail_q <= '0;
			free_q <= SW'(1); lin_q <= 1'b1; step_q <= '0;
		end else begin
			case (st_q)
				S_INIT: begin
					init_q <= init_q + SW'(1);
					if (init_q == NSL) st_q <= S_IDLE;
				end
				S_IDLE: if (s_tvalid) begin
					op_q <= i_op; val_q <= i_val; ord_q <= i_ord; sl_q <= i_sl;
					status_q <= ST_OK; rslot_q <= '0; found_q <= 1'b0;
					rval_q <= DATA_BITS'(POISON_VALUE);
					st_q <= S_DEC;
				end
				S_DEC: begin
					step_q <= '0;
					if (op_q == OP_CONTAINS) begin
						status_q <= ST_NOT_FOUND; s_q <= head_q; idx_q <= '0;
						st_q <= S_SRCH;
					end else if (is_slotop) begin
						if (sl_q == '0 || sl_q > NSL) begin
							status_q <= ST_BAD_SLOT; st_q <= S_OUT;
						end else begin
							s_q <= sl_q; st_q <= S_RDS;
						end
					end else if (is_ins) begin
						if (op_q == OP_INSERT_AFTER && ord_q > cnt_q) begin
							status_q <= ST_RANGE; st_q <= S_OUT;
						end else if (clip(free_q) == '0 || cnt_q >= NSL) begin
							status_q <= ST_FULL; st_q <= S_OUT;
						end else begin
							s_q <= clip(free_q);
							if (op_q == OP_PUSH_FRONT ||
								(op_q == OP_INSERT_AFTER && ord_q == '0)) begin
								p_q <= '0; st_q <= S_FIX;
							end else if (op_q == OP_PUSH_BACK) begin
								p_q <= clip(tail_q); st_q <= S_FIX;
							end else if (lin_q) begin
								p_q <= clip(ord_q); st_q <= S_FIX;
							end else begin
								p_q <= clip(head_q); idx_q <= SW'(1); st_q <= S_WALK;
							end
						end
					end else begin
						if (ord_q == '0 || ord_q > cnt_q) begin
							status_q <= ST_RANGE; st_q <= S_OUT;
						end else if (lin_q) begin
							s_q <= clip(ord_q); st_q <= S_LINK;
						end else begin
							p_q <= clip(head_q); idx_q <= SW'(1); st_q <= S_WALK;
						end
					end
				end
				// walk: p_q holds slot of order idx_q
				S_WALK: begin
					if (idx_q == ord_q) begin
						if (is_ins) st_q <= S_FIX;
						else begin
							s_q <= p_q; st_q <= S_LINK;
						end
					end else begin
						st_q <= S_WALKR;
					end
				end
				S_WALKR: begin
					p_q <= clip(nx_rd); idx_q <= idx_q + SW'(1); st_q <= S_WALK;
				end
				S_SRCH: begin
					if (idx_q >= cnt_q || s_q == '0) st_q <= S_OUT;
					else st_q <= S_SRCHR;
				end
				S_SRCHR: begin
					if (dt_rd == val_q) begin
						status_q <= ST_OK; found_q <= 1'b1; rslot_q <= s_q;
						rval_q <= val_q; st_q <= S_OUT;
					end else begin
						s_q <= clip(nx_rd); idx_q <= idx_q + SW'(1); st_q <= S_SRCH;
					end
				end
				S_RDS: begin
					if (!us_rd) begin
						status_q <= ST_BAD_SLOT; st_q <= S_OUT;
					end else begin
						st_q <= S_LINK;
					end
				end
				// insert: fetch next of p (or head), then advance the free chain
				S_FIX: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd1) n_q <= (p_q == '0) ? clip(head_q) : clip(nx_rd);
					if (step_q == 3'd2) begin
						free_q <= clip(nx_rd);
						step_q <= '0; st_q <= S_LINK;
					end
				end
				S_LINK: begin
					step_q <= step_q + 3'd1;
					if (is_ins) begin
						if (step_q == 3'd1) begin
							if (p_q == '0) head_q <= s_q;
							if (n_q == '0) tail_q <= s_q;
							cnt_q <= cnt_q + SW'(1);
							if (op_q != OP_PUSH_BACK) lin_q <= 1'b0;
							rslot_q <= s_q; rval_q <= val_q; st_q <= S_OUT;
						end
					end else begin
						if (step_q == 3'd1) begin
							p_q <= clip(pv_rd); n_q <= clip(nx_rd);
							rslot_q <= s_q; rval_q <= dt_rd;
							if (op_q == OP_READ_ORDER || op_q == OP_READ_SLOT)
								st_q <= S_OUT;
						end
						if (step_q == 3'd2) begin
							if (p_q == '0) head_q <= n_q;
							if (n_q == '0) tail_q <= p_q;
						end
						if (step_q == 3'd3) begin
							free_q <= s_q; cnt_q <= cnt_q - SW'(1);
							lin_q <= 1'b0; st_q <= S_OUT;
						end
					end
				end
				S_OUT: if (m_tready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

### rtl/all_mem.sv
// Simple dual-port memory (one write, one read port) with registered read for the list engine.
// Depends on nothing.
module all_mem #(
	parameter int AW = 9,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
